### sv/lbh_pkg.sv
// Shared types, constants and the mix-round function of the lookup2 byte hash.
// No dependencies; imported by every module of the block.
package lbh_pkg;

   localparam logic [31:0] GoldenRatio = 32'h9e3779b9;
   localparam int          BlockLen    = 12;
   localparam int          BlockBits   = 8 * BlockLen;
   localparam int          MixRounds   = 9;
   localparam int          FillW       = $clog2(BlockLen);
   localparam int          RoundW      = $clog2(MixRounds);

   localparam logic [FillW-1:0]  LastFill  = FillW'(BlockLen - 1);
   localparam logic [RoundW-1:0] LastRound = RoundW'(MixRounds - 1);

   // shift amount per mix round; rounds on b shift left, all others shift right
   localparam logic [4:0] MixShift [MixRounds] = '{
      5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
   };

   // which of a, b, c a mix round updates
   typedef enum logic [1:0] {
      LANE_A,
      LANE_B,
      LANE_C
   } lbh_lane_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_COUNT,
      ST_DONE
   } lbh_state_type;

   // one unit of work for the mixer: a full block, a message end, or both
   typedef struct packed {
      logic        blk;
      logic        fin;
      logic [31:0] wa;
      logic [31:0] wb;
      logic [31:0] wc;
      logic [31:0] cnt;
   } lbh_job_type;

   // x = (x - y - z) ^ (z shifted)
   function automatic logic [31:0] lbh_round(input logic [31:0] x,
                                             input logic [31:0] y,
                                             input logic [31:0] z,
                                             input logic [4:0]  sh,
                                             input logic        left);
      logic [31:0] diff;
      logic [31:0] shz;
      diff = x - y - z;
      shz  = left ? (z << sh) : (z >> sh);
      return diff ^ shz;
   endfunction

endpackage

### sv/lbh_front.sv
// Byte packer: takes message bytes, builds 12-byte blocks and issues mixer jobs.
// Depends on lbh_pkg.
module lbh_front
   import lbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  logic [7:0]   req_data_byte,
   input  logic         req_last,
   input  logic         req_empty_message,
   output logic         job_push,
   output lbh_job_type  job_data
);

   logic [FillW-1:0]     fill_ff, fill_in;
   logic [31:0]          count_ff, count_in;
   logic [BlockBits-1:0] blk_ff, blk_in;
   logic                 accept;
   logic                 blk_done;
   logic [BlockBits-1:0] blk_ins;
   logic [31:0]          count_inc;

   assign accept    = req_push && !req_full;
   assign count_inc = count_ff + 32'd1;
   assign blk_done  = (fill_ff == LastFill);

   // byte goes into its lane; starting a new block clears the stale lanes
   always_comb begin
      for (int i = 0; i < BlockLen; i++) begin
         if (fill_ff == FillW'(i))
            blk_ins[8*i +: 8] = req_data_byte;
         else if (fill_ff == '0)
            blk_ins[8*i +: 8] = 8'h00;
         else
            blk_ins[8*i +: 8] = blk_ff[8*i +: 8];
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      blk_in   = blk_ff;
      job_push = 1'b0;
      job_data = '0;
      if (accept) begin
         if (req_empty_message) begin
            job_push     = 1'b1;
            job_data.fin = 1'b1;
            job_data.cnt = count_ff;
            if (fill_ff != '0) begin
               job_data.wa = blk_ff[31:0];
               job_data.wb = blk_ff[63:32];
               job_data.wc = {blk_ff[87:64], 8'h00};
            end
            fill_in  = '0;
            count_in = '0;
         end else begin
            blk_in       = blk_ins;
            job_push     = blk_done || req_last;
            job_data.blk = blk_done;
            job_data.fin = req_last;
            job_data.cnt = count_inc;
            job_data.wa  = blk_ins[31:0];
            job_data.wb  = blk_ins[63:32];
            job_data.wc  = blk_done ? blk_ins[95:64] : {blk_ins[87:64], 8'h00};
            fill_in      = (blk_done || req_last) ? '0 : fill_ff + FillW'(1);
            count_in     = req_last ? '0 : count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
      blk_ff <= blk_in;
   end

endmodule

### sv/lbh_jobq.sv
// Two-entry job queue between the byte packer and the mixer.
// Depends on lbh_pkg.
module lbh_jobq
   import lbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lbh_job_type  push_data,
   output logic         full,
   input  logic         pop,
   output logic         avail,
   output lbh_job_type  head
);

   lbh_job_type slot_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  used_ff, used_in;
   logic        do_push, do_pop;

   assign full    = (used_ff == 2'd2);
   assign avail   = (used_ff != 2'd0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && avail;

   always_comb begin
      wr_in   = do_push ? !wr_ff : wr_ff;
      rd_in   = do_pop ? !rd_ff : rd_ff;
      used_in = used_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         used_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         used_ff <= used_in;
      end
      if (do_push)
         slot_ff[wr_ff] <= push_data;
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= 2'd2) else $error("job queue over capacity");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into full queue");
   a_pop_avail: assert property (@(posedge clock) disable iff (reset)
      pop |-> avail) else $error("job popped from empty queue");

endmodule

### sv/lbh_back.sv
// Mixer: folds jobs into a, b, c, runs the nine-round mix one round a cycle and
// holds the finished hash in an output register. Depends on lbh_pkg.
module lbh_back
   import lbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_avail,
   input  lbh_job_type  job_head,
   output logic         job_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [31:0]  rsp_hash_value
);

   lbh_state_type     state_ff, state_in;
   logic [31:0]       a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [31:0]       cnt_ff, cnt_in;
   logic              need_cnt_ff, need_cnt_in;
   logic              fin_ff, fin_in;
   logic [RoundW-1:0] round_ff, round_in;
   lbh_lane_type      lane_ff, lane_in;
   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_hash_ff, out_hash_in;
   logic [4:0]        sh;

   assign sh             = MixShift[round_ff];
   assign rsp_empty      = !out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      cnt_in       = cnt_ff;
      need_cnt_in  = need_cnt_ff;
      fin_in       = fin_ff;
      round_in     = round_ff;
      lane_in      = lane_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_hash_in  = out_hash_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_avail) begin
               job_pop     = 1'b1;
               a_in        = a_ff + job_head.wa;
               b_in        = b_ff + job_head.wb;
               // count joins c here unless a block mix has to run first
               c_in        = c_ff + job_head.wc +
                             ((job_head.fin && !job_head.blk) ? job_head.cnt : 32'd0);
               cnt_in      = job_head.cnt;
               need_cnt_in = job_head.fin && job_head.blk;
               fin_in      = job_head.fin;
               round_in    = '0;
               lane_in     = LANE_A;
               state_in    = ST_MIX;
            end
         end
         ST_MIX: begin
            unique case (lane_ff)
               LANE_A: begin
                  a_in    = lbh_round(a_ff, b_ff, c_ff, sh, 1'b0);
                  lane_in = LANE_B;
               end
               LANE_B: begin
                  b_in    = lbh_round(b_ff, c_ff, a_ff, sh, 1'b1);
                  lane_in = LANE_C;
               end
               LANE_C: begin
                  c_in    = lbh_round(c_ff, a_ff, b_ff, sh, 1'b0);
                  lane_in = LANE_A;
               end
               default: lane_in = LANE_A;
            endcase
            round_in = round_ff + RoundW'(1);
            if (round_ff == LastRound) begin
               round_in = '0;
               if (need_cnt_ff)
                  state_in = ST_COUNT;
               else if (fin_ff)
                  state_in = ST_DONE;
               else
                  state_in = ST_IDLE;
            end
         end
         ST_COUNT: begin
            c_in        = c_ff + cnt_ff;
            need_cnt_in = 1'b0;
            round_in    = '0;
            lane_in     = LANE_A;
            state_in    = ST_MIX;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_hash_in  = c_ff;
               a_in         = GoldenRatio;
               b_in         = GoldenRatio;
               c_in         = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_ff         <= GoldenRatio;
         b_ff         <= GoldenRatio;
         c_ff         <= '0;
         need_cnt_ff  <= 1'b0;
         fin_ff       <= 1'b0;
         round_ff     <= '0;
         lane_ff      <= LANE_A;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         need_cnt_ff  <= need_cnt_in;
         fin_ff       <= fin_in;
         round_ff     <= round_in;
         lane_ff      <= lane_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff      <= cnt_in;
      out_hash_ff <= out_hash_in;
   end

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      round_ff <= LastRound) else $error("mix round out of range");
   a_cnt_implies_fin: assert property (@(posedge clock) disable iff (reset)
      need_cnt_ff |-> fin_ff) else $error("pending count without message end");
   a_hash_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_hash_ff))
      else $error("waiting hash lost or overwritten");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == ST_IDLE) else $error("job taken while mixing");

endmodule

### sv/lookup2_byte_hash.sv
// Lookup2 hash of a byte stream.
// Depends on lbh_pkg, lbh_front, lbh_jobq and lbh_back.
//
// Input channel: req_push / req_full, one message byte per transfer with
// req_last on the final byte; req_empty_message ends the message without a
// byte (a zero-length message when no bytes came before). Result channel:
// rsp_empty / rsp_pop, one 32-bit rsp_hash_value per message.
// The packer takes one byte a cycle while req_full is low. Each 12-byte block
// becomes a job in a two-entry queue; the mixer loads a job in ST_IDLE and
// runs the nine mix rounds one per cycle, and takes no new job until it is
// through with the last one. A message end passes through ST_IDLE, the nine
// rounds and ST_DONE, which loads the output register; when the final byte
// completes a block, ST_COUNT adds the length and the nine rounds run again
// before ST_DONE. Short messages are thus bounded by the mixer.
// Reset (synchronous) empties the queue and output register and returns the
// hash state to its initial value. If the result is not popped, the mixer
// holds the next hash, the queue fills and req_full rises.
module lookup2_byte_hash
   import lbh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        req_empty_message,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_hash_value
);

   logic        job_push;
   lbh_job_type job_data;
   logic        job_pop;
   logic        job_avail;
   lbh_job_type job_head;

   lbh_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .req_empty_message (req_empty_message),
      .job_push          (job_push),
      .job_data          (job_data)
   );

   lbh_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (req_full),
      .pop       (job_pop),
      .avail     (job_avail),
      .head      (job_head)
   );

   lbh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_avail      (job_avail),
      .job_head       (job_head),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

### tb/lbh_hash_checker.sv
// Scoreboard for the lookup2 byte hash: watches both channels, predicts each hash.
// Standalone predictor; depends only on the port list of lookup2_byte_hash.
module lbh_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        req_empty_message,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_hash_value,
   output int          failures,
   output int          pending
);

   localparam int          BlockBytes = 12;
   localparam int          MaxReports = 10;
   localparam logic [31:0] InitAB     = 32'h9e3779b9;

   logic [31:0] mix_a;
   logic [31:0] mix_b;
   logic [31:0] mix_c;
   logic [31:0] msg_bytes;
   logic [7:0]  blk [BlockBytes];
   int          fill;
   logic [31:0] hash_expected_q [$];

   function automatic void lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
                                       inout logic [31:0] c);
      a = (a - b - c) ^ (c >> 13);
      b = (b - c - a) ^ (a << 8);
      c = (c - a - b) ^ (b >> 13);
      a = (a - b - c) ^ (c >> 12);
      b = (b - c - a) ^ (a << 16);
      c = (c - a - b) ^ (b >> 5);
      a = (a - b - c) ^ (c >> 3);
      b = (b - c - a) ^ (a << 10);
      c = (c - a - b) ^ (b >> 15);
   endfunction

   function automatic void restart_message();
      mix_a     = InitAB;
      mix_b     = InitAB;
      mix_c     = '0;
      msg_bytes = '0;
      fill      = 0;
   endfunction

   // tail bytes go to a, b and c[31:8]; the length is added to c
   function automatic logic [31:0] close_message();
      logic [31:0] h;
      logic [31:0] v;
      mix_c = mix_c + msg_bytes;
      for (int i = 0; i < fill; i++) begin
         v = {24'd0, blk[i]};
         if (i < 4)
            mix_a = mix_a + (v << (8 * i));
         else if (i < 8)
            mix_b = mix_b + (v << (8 * (i - 4)));
         else
            mix_c = mix_c + (v << (8 * (i - 8) + 8));
      end
      lookup2_mix(mix_a, mix_b, mix_c);
      h = mix_c;
      restart_message();
      return h;
   endfunction

   // returns 1 when the transfer finishes a message
   function automatic bit absorb_item(input logic [7:0] d, input logic l, input logic e,
                                      output logic [31:0] h);
      h = '0;
      if (e) begin
         h = close_message();
         return 1'b1;
      end
      blk[fill] = d;
      fill++;
      msg_bytes = msg_bytes + 32'd1;
      if (fill == BlockBytes) begin
         mix_a = mix_a + {blk[3], blk[2], blk[1], blk[0]};
         mix_b = mix_b + {blk[7], blk[6], blk[5], blk[4]};
         mix_c = mix_c + {blk[11], blk[10], blk[9], blk[8]};
         lookup2_mix(mix_a, mix_b, mix_c);
         fill = 0;
      end
      if (l) begin
         h = close_message();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= MaxReports)
         $display("[%0t] %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      logic [31:0] h;
      logic [31:0] want;
      if (reset) begin
         restart_message();
         hash_expected_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (hash_expected_q.size() == 0) begin
               log_failure($sformatf("unexpected hash %08h, nothing pending", rsp_hash_value));
            end else begin
               want = hash_expected_q.pop_front();
               if (rsp_hash_value !== want)
                  log_failure($sformatf("hash_value mismatch: expected %08h, got %08h",
                                        want, rsp_hash_value));
            end
         end
         if (req_push && !req_full) begin
            if (absorb_item(req_data_byte, req_last, req_empty_message, h))
               hash_expected_q.push_back(h);
         end
      end
      pending = hash_expected_q.size();
   end

endmodule

### tb/testbench.sv
// Top of the lookup2_byte_hash testbench: clock, reset, byte stimulus, pop pacing.
// Depends on lookup2_byte_hash (and its package) and lbh_hash_checker.
module testbench;

   localparam int ItemTarget = 1400;
   localparam int CalmFrom   = 1150;
   localparam int HoldAt     = 300;
   localparam int HoldCycles = 400;
   localparam int DrainWait  = 40;
   localparam int IdleLimit  = 4000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        req_last;
   logic        req_empty_message;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_hash_value;

   int failures;
   int pending;
   int items_sent = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;
   bit hold_done = 1'b0;

   lookup2_byte_hash dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .req_empty_message (req_empty_message),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_hash_value    (rsp_hash_value)
   );

   lbh_hash_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .req_empty_message (req_empty_message),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_hash_value    (rsp_hash_value),
      .failures          (failures),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // one transfer; may leave a sender gap behind it
   task automatic send_item(input logic [7:0] d, input logic l, input logic e);
      req_push          <= 1'b1;
      req_data_byte     <= d;
      req_last          <= l;
      req_empty_message <= e;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // mostly well-formed messages; some end by the empty flag after bytes
   task automatic send_message();
      int kind;
      int pick;
      int len;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         send_item(8'($urandom), 1'($urandom), 1'b1);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            len = $urandom_range(1, 26);
         else if (pick < 95)
            len = $urandom_range(1, 60);
         else
            len = $urandom_range(61, 150);
         for (int i = 0; i < len; i++)
            send_item(8'($urandom), (kind != 1) && (i == len - 1), 1'b0);
         if (kind == 1)
            send_item(8'($urandom), 1'($urandom), 1'b1);
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_push          <= 1'b0;
      req_data_byte     <= '0;
      req_last          <= 1'b0;
      req_empty_message <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message, also with last low and data set; then two one-byte messages
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      // final byte completes a block: no tail bytes
      for (int i = 0; i < 12; i++)
         send_item(8'hff, i == 11, 1'b0);
      // empty flag ends a message that already holds bytes
      send_item(8'ha5, 1'b0, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'h01, 1'b0, 1'b1);

      while (items_sent < ItemTarget) begin
         if (items_sent >= CalmFrom)
            calm = 1'b1;
         send_message();
      end
      req_push <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS lookup2_byte_hash");
      else
         $display("FAIL lookup2_byte_hash");
      $finish;
   end

   // receiver pacing, with one long hold so the input backs up
   initial begin
      rsp_pop <= 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HoldAt) begin
            rsp_pop <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("FAIL lookup2_byte_hash");
         $finish;
      end
   end

endmodule

### lookup2_byte_hash.f
sv/lbh_pkg.sv
sv/lbh_front.sv
sv/lbh_jobq.sv
sv/lbh_back.sv
sv/lookup2_byte_hash.sv
tb/lbh_hash_checker.sv
tb/testbench.sv
